@@ design/korl_pkg.sv @@
package korl_pkg;

    // Sizing
    localparam int DEPTH       = 16;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ID_W        = 31;
    localparam int PAY_W       = 32;
    localparam int REC_W       = ID_W + PAY_W;
    localparam int CNT_FIELD_W = 5;

    // Command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_LOOKUP     = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_COUNT      = 3'd7
    } command_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        command_t           command;
        logic [ID_W-1:0]    key_id;
        logic [PAY_W-1:0]   record_payload;
    } request_t;

    typedef struct packed {
        status_t                status;
        logic [ID_W-1:0]        found_id;
        logic [PAY_W-1:0]       found_payload;
        logic [CNT_FIELD_W-1:0] entry_count;
    } result_t;

    // Link held by a slot whose link was never written since reset or clear
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(DEPTH - 1))
        begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    // Count as reported: low bits of the held count
    function automatic logic [CNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[CNT_FIELD_W-1:0];
    endfunction

endpackage

@@ design/korl_ram.sv @@
module korl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/keyed_ordered_record_list.sv @@
// Keyed ordered record list: up to DEPTH records (identifier + payload)
// chained through a link memory, with a free chain for unused slots.
//
// Request channel: a request (command, key_id, record_payload) is taken on
// a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with the result; the
// receiver cannot stall it, so results are never held back.
//
// Command flow: count, clear, and any command rejected as
// full or empty answer in the next cycle (busy stays low). A push is busy
// while it writes the record and links it in. Pop front, pop back, remove
// and lookup walk the chain one slot per cycle (one link read and one record
// read per cycle); pops and removes then return the slot to the free chain
// before they answer.
//
// Reset: list empty, free chain runs 0, 1, 2, ...; a valid bit per link
// entry makes unwritten links read as the following slot, so no clearing
// pass is needed. Clear drops all those valid bits together.
module keyed_ordered_record_list
    import korl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_WALK = 4'b0100,
        S_GIVE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;

    command_t         cmd_reg;
    logic [ID_W-1:0]  key_reg;
    logic [PAY_W-1:0] pay_reg;

    logic [DEPTH-1:0]  lvalid_reg;
    logic              lv_q_reg;
    logic [SLOT_W-1:0] raddr_q_reg;

    logic    done_reg, done_next;
    result_t result_reg, result_next;

    // Memory ports
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_raddr;
    logic [SLOT_W-1:0] link_rdata;
    logic              rec_we;
    logic [REC_W-1:0]  rec_rdata;
    logic              lvalid_clear;

    logic              accept;
    logic [SLOT_W-1:0] link_val;
    logic              last_pos;
    logic              hit;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Link and record memories, both read at the same slot
    korl_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    korl_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (free_reg),
        .wdata ({key_reg, pay_reg}),
        .raddr (link_raddr),
        .rdata (rec_rdata)
    );

    // Unwritten links read as the following slot
    assign link_val = lv_q_reg ? link_rdata : next_slot(raddr_q_reg);

    assign last_pos = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);

    // Walk match: position for pops, identifier for remove and lookup
    always_comb
    begin
        case (cmd_reg)
            CMD_POP_FRONT: hit = (pos_reg == '0);
            CMD_POP_BACK:  hit = last_pos;
            default:       hit = (rec_rdata[REC_W-1:PAY_W] == key_reg);
        endcase
    end

    // Sequencer. A read issued in a cycle that writes is never used: writes
    // happen only in the closing steps of a command, and the next read used comes later.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        pos_next     = pos_reg;
        link_we      = 1'b0;
        link_waddr   = cur_reg;
        link_wdata   = free_reg;
        link_raddr   = head_reg;
        rec_we       = 1'b0;
        lvalid_clear = 1'b0;
        done_next    = 1'b0;
        result_next  = '0;
        result_next.status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                link_raddr = free_reg;
                                state_next = S_PUSH;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE, CMD_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                link_raddr = head_reg;
                                cur_next   = head_reg;
                                prev_next  = '0;
                                pos_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next    = '0;
                            tail_next    = '0;
                            free_next    = '0;
                            count_next   = '0;
                            lvalid_clear = 1'b1;
                            done_next    = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Take the free head slot and link it in
            S_PUSH:
            begin
                rec_we    = 1'b1;
                free_next = link_val;
                if (count_reg == '0)
                begin
                    head_next = free_reg;
                    tail_next = free_reg;
                end
                else if (cmd_reg == CMD_PUSH_FRONT)
                begin
                    link_we    = 1'b1;
                    link_waddr = free_reg;
                    link_wdata = head_reg;
                    head_next  = free_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg;
                    link_wdata = free_reg;
                    tail_next  = free_reg;
                end
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // One slot per cycle; the next read address is this link
            S_WALK:
            begin
                link_raddr = link_val;
                if (hit)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        done_next                 = 1'b1;
                        result_next.found_id      = rec_rdata[REC_W-1:PAY_W];
                        result_next.found_payload = rec_rdata[PAY_W-1:0];
                        state_next                = S_IDLE;
                    end
                    else
                    begin
                        if (pos_reg == '0)
                        begin
                            head_next = link_val;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = link_val;
                            if (last_pos)
                            begin
                                tail_next = prev_reg;
                            end
                        end
                        state_next = S_GIVE;
                    end
                end
                else if (last_pos)
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_NOTFOUND;
                    state_next         = S_IDLE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_val;
                    pos_next  = pos_reg + SLOT_W'(1);
                end
            end

            // Return the unlinked slot to the free chain
            S_GIVE:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = free_reg;
                free_next  = cur_reg;
                count_next = count_reg - CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.entry_count = count_field(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            lvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (lvalid_clear)
            begin
                lvalid_reg <= '0;
            end
            else if (link_we)
            begin
                lvalid_reg[link_waddr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= request.command;
            key_reg <= request.key_id;
            pay_reg <= request.record_payload;
        end
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        pos_reg     <= pos_next;
        lv_q_reg    <= lvalid_reg[link_raddr];
        raddr_q_reg <= link_raddr;
        result_reg  <= result_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count above depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while busy");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept || (state_reg != S_IDLE)))
        else $error("result without a request");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CNT_W'(pos_reg) < count_reg))
        else $error("walk ran past the list end");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (count_reg == CNT_W'(DEPTH))
            && ((request.command == CMD_PUSH_FRONT) || (request.command == CMD_PUSH_BACK)))
        |=> (done_reg && (result_reg.status == ST_FULL)))
        else $error("push on full list not flagged");

endmodule
